// File: hdl/ckbb_pkg.sv
package ckbb_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int OUT_W          = 12;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_IDX_W      = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_KEY_RED      = 3'd0;
	localparam cfg_idx_t CFG_KEY_GREEN    = 3'd1;
	localparam cfg_idx_t CFG_KEY_BLUE     = 3'd2;
	localparam cfg_idx_t CFG_KEY_ENABLE   = 3'd3;
	localparam cfg_idx_t CFG_FRAME_WIDTH  = 3'd4;
	localparam cfg_idx_t CFG_FRAME_HEIGHT = 3'd5;

	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd256;
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd144;

	typedef struct packed {
		logic [7:0]            key_red;
		logic [7:0]            key_green;
		logic [7:0]            key_blue;
		logic                  key_enable;
		logic [CFG_DATA_W-1:0] frame_width;
		logic [CFG_DATA_W-1:0] frame_height;
	} cfg_t;

	typedef struct packed {
		logic             found;
		logic [OUT_W-1:0] box_min_col;
		logic [OUT_W-1:0] box_max_col;
		logic [OUT_W-1:0] box_min_row;
		logic [OUT_W-1:0] box_max_row;
		logic [OUT_W-1:0] center_col;
		logic [OUT_W-1:0] center_row;
	} result_t;

endpackage

// File: hdl/color_key_bounding_box_top.sv
// Color key bounding box.
// Pixels arrive in raster order on the pix channel (pix_valid, pix_stall), one item
// per cycle at full rate unless stalled; the alpha byte is ignored. Column and row
// counters follow the configured frame size, and every pixel equal to the enabled
// key widens the box. After the last pixel of each frame one result item leaves on
// the res channel (res_valid, res_stall): found flag, box and center. With no match,
// all fields are 0. Throughput is one pixel per cycle unless stalled. A result is
// built from the last pixel of its frame: the pixel waits in the input register while
// the compare and select logic feeds the result register.
// Registers are written over the cfg channel; cfg_ready is always high, and the user
// must make writes only while no pixel is in flight; the block does not enforce this.
// When the receiver stalls, a waiting result is held in the output register and one
// more result fits in a skid entry; pix_stall is raised only while that entry is full.
// Reset clears the counters and the box and loads the register reset values.
module color_key_bounding_box_top #(
	parameter int COORD_BITS = ckbb_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  ckbb_pkg::cfg_idx_t                cfg_index,
	input  logic [ckbb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic [7:0]                        pixel_red,
	input  logic [7:0]                        pixel_green,
	input  logic [7:0]                        pixel_blue,
	input  logic [7:0]                        pixel_alpha,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              found,
	output logic [ckbb_pkg::OUT_W-1:0]        box_min_col,
	output logic [ckbb_pkg::OUT_W-1:0]        box_max_col,
	output logic [ckbb_pkg::OUT_W-1:0]        box_min_row,
	output logic [ckbb_pkg::OUT_W-1:0]        box_max_row,
	output logic [ckbb_pkg::OUT_W-1:0]        center_col,
	output logic [ckbb_pkg::OUT_W-1:0]        center_row
);

	ckbb_pkg::cfg_t    cfg_q;
	ckbb_pkg::result_t res_data, res_out;
	logic              res_new, hold;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_red      <= '0;
			cfg_q.key_green    <= '0;
			cfg_q.key_blue     <= '0;
			cfg_q.key_enable   <= 1'b0;
			cfg_q.frame_width  <= ckbb_pkg::FRAME_WIDTH_RST;
			cfg_q.frame_height <= ckbb_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ckbb_pkg::CFG_KEY_RED:      cfg_q.key_red      <= cfg_data[7:0];
				ckbb_pkg::CFG_KEY_GREEN:    cfg_q.key_green    <= cfg_data[7:0];
				ckbb_pkg::CFG_KEY_BLUE:     cfg_q.key_blue     <= cfg_data[7:0];
				ckbb_pkg::CFG_KEY_ENABLE:   cfg_q.key_enable   <= cfg_data[0];
				ckbb_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				ckbb_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				default: ;
			endcase
		end
	end

	ckbb_box_tracker #(
		.COORD_BITS(COORD_BITS)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.hold        (hold),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.res_new     (res_new),
		.res_data    (res_data)
	);

	ckbb_result_buffer u_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_new   (res_new),
		.res_data  (res_data),
		.hold      (hold),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_out   (res_out)
	);

	assign found       = res_out.found;
	assign box_min_col = res_out.box_min_col;
	assign box_max_col = res_out.box_max_col;
	assign box_min_row = res_out.box_min_row;
	assign box_max_row = res_out.box_max_row;
	assign center_col  = res_out.center_col;
	assign center_row  = res_out.center_row;

endmodule

// File: hdl/ckbb_box_tracker.sv
module ckbb_box_tracker #(
	parameter int COORD_BITS = ckbb_pkg::COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ckbb_pkg::cfg_t      cfg,
	input  logic                hold,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  logic [7:0]          pixel_red,
	input  logic [7:0]          pixel_green,
	input  logic [7:0]          pixel_blue,
	output logic                res_new,
	output ckbb_pkg::result_t   res_data
);

	localparam int CMP_W = (COORD_BITS + 1 > ckbb_pkg::CFG_DATA_W) ?
		COORD_BITS + 1 : ckbb_pkg::CFG_DATA_W;
	localparam int EXT_W = (COORD_BITS > ckbb_pkg::OUT_W) ? COORD_BITS : ckbb_pkg::OUT_W;
	localparam logic [CMP_W-1:0] SPAN = CMP_W'(1) << COORD_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;

	function automatic logic [ckbb_pkg::OUT_W-1:0] to_out(input coord_t v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[ckbb_pkg::OUT_W-1:0];
	endfunction

	logic       pix_v_s1;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;

	coord_t col_q, row_q;
	coord_t min_col_q, max_col_q, min_row_q, max_row_q;
	logic   any_q;

	logic             advance, match, col_last, row_last, frame_end;
	logic [CMP_W-1:0] width_eff, height_eff, col_next, row_next;
	coord_t           upd_min_col, upd_max_col, upd_min_row, upd_max_row;
	logic             upd_any;
	logic [COORD_BITS:0] sum_col, sum_row;

	assign pix_stall = hold;
	assign advance   = pix_v_s1 & ~hold;

	assign match = cfg.key_enable && (red_s1 == cfg.key_red) &&
		(green_s1 == cfg.key_green) && (blue_s1 == cfg.key_blue);

	always_comb begin
		// A size of zero acts as one, a size beyond the counter span acts as the span.
		if (cfg.frame_width == '0) begin
			width_eff = CMP_W'(1);
		end else if (CMP_W'(cfg.frame_width) > SPAN) begin
			width_eff = SPAN;
		end else begin
			width_eff = CMP_W'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			height_eff = CMP_W'(1);
		end else if (CMP_W'(cfg.frame_height) > SPAN) begin
			height_eff = SPAN;
		end else begin
			height_eff = CMP_W'(cfg.frame_height);
		end
	end

	assign col_next  = CMP_W'(col_q) + CMP_W'(1);
	assign row_next  = CMP_W'(row_q) + CMP_W'(1);
	assign col_last  = col_next >= width_eff;
	assign row_last  = row_next >= height_eff;
	assign frame_end = col_last && row_last;

	assign upd_min_col = (match && col_q < min_col_q) ? col_q : min_col_q;
	assign upd_max_col = (match && col_q > max_col_q) ? col_q : max_col_q;
	assign upd_min_row = (match && row_q < min_row_q) ? row_q : min_row_q;
	assign upd_max_row = (match && row_q > max_row_q) ? row_q : max_row_q;
	assign upd_any     = any_q | match;

	assign sum_col = (COORD_BITS + 1)'(upd_min_col) + (COORD_BITS + 1)'(upd_max_col);
	assign sum_row = (COORD_BITS + 1)'(upd_min_row) + (COORD_BITS + 1)'(upd_max_row);

	always_comb begin
		res_data = '0;
		if (upd_any) begin
			res_data.found       = 1'b1;
			res_data.box_min_col = to_out(upd_min_col);
			res_data.box_max_col = to_out(upd_max_col);
			res_data.box_min_row = to_out(upd_min_row);
			res_data.box_max_row = to_out(upd_max_row);
			res_data.center_col  = to_out(sum_col[COORD_BITS:1]);
			res_data.center_row  = to_out(sum_row[COORD_BITS:1]);
		end
	end

	assign res_new = advance && frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_v_s1  <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			any_q     <= 1'b0;
		end else begin
			if (!hold) begin
				pix_v_s1 <= pix_valid;
			end
			if (advance) begin
				if (frame_end) begin
					col_q     <= '0;
					row_q     <= '0;
					min_col_q <= '1;
					max_col_q <= '0;
					min_row_q <= '1;
					max_row_q <= '0;
					any_q     <= 1'b0;
				end else begin
					min_col_q <= upd_min_col;
					max_col_q <= upd_max_col;
					min_row_q <= upd_min_row;
					max_row_q <= upd_max_row;
					any_q     <= upd_any;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_next[COORD_BITS-1:0];
					end else begin
						col_q <= col_next[COORD_BITS-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && pix_valid) begin
			red_s1   <= pixel_red;
			green_s1 <= pixel_green;
			blue_s1  <= pixel_blue;
		end
	end

endmodule

// File: hdl/ckbb_result_buffer.sv
module ckbb_result_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_new,
	input  ckbb_pkg::result_t res_data,
	output logic              hold,
	output logic              res_valid,
	input  logic              res_stall,
	output ckbb_pkg::result_t res_out
);

	logic              out_v_q, skid_v_q;
	ckbb_pkg::result_t out_q, skid_q;
	logic              out_free;

	assign out_free  = ~out_v_q | ~res_stall;
	assign hold      = skid_v_q;
	assign res_valid = out_v_q;
	assign res_out   = out_q;

	// A new item only arrives while the skid entry is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q | res_new;
			skid_v_q <= 1'b0;
		end else if (res_new) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res_data;
		end else if (res_new) begin
			skid_q <= res_data;
		end
	end

endmodule

// File: hdl/ckbb_checker.sv
module ckbb_checker #(
	parameter int COORD_BITS = ckbb_pkg::COORD_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_stall,
	input logic                       found,
	input logic [ckbb_pkg::OUT_W-1:0] box_min_col,
	input logic [ckbb_pkg::OUT_W-1:0] box_max_col,
	input logic [ckbb_pkg::OUT_W-1:0] box_min_row,
	input logic [ckbb_pkg::OUT_W-1:0] box_max_row,
	input logic [ckbb_pkg::OUT_W-1:0] center_col,
	input logic [ckbb_pkg::OUT_W-1:0] center_row
);

	localparam bit FULL_COORDS = COORD_BITS <= ckbb_pkg::OUT_W;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(found) &&
			$stable(box_min_col) && $stable(center_row))
		else $error("stalled result item changed or dropped");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> box_min_col == '0 && box_max_col == '0 &&
			box_min_row == '0 && box_max_row == '0 && center_col == '0 && center_row == '0)
		else $error("result without a match has nonzero box fields");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && found && FULL_COORDS |->
			box_min_col <= box_max_col && box_min_row <= box_max_row)
		else $error("box minimum exceeds maximum");

	a_center_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && found && FULL_COORDS |->
			center_col >= box_min_col && center_col <= box_max_col &&
			center_row >= box_min_row && center_row <= box_max_row)
		else $error("center lies outside the box");

endmodule

bind color_key_bounding_box_top ckbb_checker #(
	.COORD_BITS(COORD_BITS)
) u_ckbb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.found       (found),
	.box_min_col (box_min_col),
	.box_max_col (box_max_col),
	.box_min_row (box_min_row),
	.box_max_row (box_max_row),
	.center_col  (center_col),
	.center_row  (center_row)
);

// File: test/bounding_box_checker.sv
module bounding_box_checker import ckbb_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	input  logic                  pix_stall,
	input  logic [7:0]            pixel_red,
	input  logic [7:0]            pixel_green,
	input  logic [7:0]            pixel_blue,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  logic                  found,
	input  logic [OUT_W-1:0]      box_min_col,
	input  logic [OUT_W-1:0]      box_max_col,
	input  logic [OUT_W-1:0]      box_min_row,
	input  logic [OUT_W-1:0]      box_max_row,
	input  logic [OUT_W-1:0]      center_col,
	input  logic [OUT_W-1:0]      center_row,
	output int                    mismatches,
	output int                    boxes_waiting
);

	localparam int SPAN = 1 << COORD_BITS;
	localparam int MASK = SPAN - 1;

	cfg_t    search;
	int      col_pos;
	int      row_pos;
	int      lo_col;
	int      hi_col;
	int      lo_row;
	int      hi_row;
	bit      seen_key;
	int      errs = 0;
	result_t expected_boxes[$];

	function automatic int eff_size(logic [CFG_DATA_W-1:0] code);
		if (code == '0)
			return 1;
		if (int'(code) > SPAN)
			return SPAN;
		return int'(code);
	endfunction

	task automatic clear_box();
		lo_col = MASK;
		hi_col = 0;
		lo_row = MASK;
		hi_row = 0;
		seen_key = 1'b0;
	endtask

	task automatic track_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int      w;
		int      h;
		result_t box;
		w = eff_size(search.frame_width);
		h = eff_size(search.frame_height);
		if (search.key_enable && r == search.key_red && g == search.key_green &&
				b == search.key_blue) begin
			if (col_pos < lo_col)
				lo_col = col_pos;
			if (col_pos > hi_col)
				hi_col = col_pos;
			if (row_pos < lo_row)
				lo_row = row_pos;
			if (row_pos > hi_row)
				hi_row = row_pos;
			seen_key = 1'b1;
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				box = '0;
				if (seen_key) begin
					box.found       = 1'b1;
					box.box_min_col = OUT_W'(lo_col);
					box.box_max_col = OUT_W'(hi_col);
					box.box_min_row = OUT_W'(lo_row);
					box.box_max_row = OUT_W'(hi_row);
					box.center_col  = OUT_W'(((lo_col + hi_col) >> 1) & MASK);
					box.center_row  = OUT_W'(((lo_row + hi_row) >> 1) & MASK);
				end
				expected_boxes.push_back(box);
				clear_box();
			end else begin
				row_pos = (row_pos + 1) & MASK;
			end
		end else begin
			col_pos = (col_pos + 1) & MASK;
		end
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errs++;
		end
	endtask

	task automatic check_box();
		result_t want;
		if (expected_boxes.size() == 0) begin
			$error("result item arrived with no box expected");
			errs++;
			return;
		end
		want = expected_boxes.pop_front();
		check_field("found", want.found, found);
		check_field("box_min_col", want.box_min_col, box_min_col);
		check_field("box_max_col", want.box_max_col, box_max_col);
		check_field("box_min_row", want.box_min_row, box_min_row);
		check_field("box_max_row", want.box_max_row, box_max_row);
		check_field("center_col", want.center_col, center_col);
		check_field("center_row", want.center_row, center_row);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search.key_red      = '0;
			search.key_green    = '0;
			search.key_blue     = '0;
			search.key_enable   = 1'b0;
			search.frame_width  = FRAME_WIDTH_RST;
			search.frame_height = FRAME_HEIGHT_RST;
			col_pos = 0;
			row_pos = 0;
			clear_box();
			expected_boxes.delete();
			errs = 0;
			mismatches    <= 0;
			boxes_waiting <= 0;
		end else begin
			if (res_valid && !res_stall)
				check_box();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KEY_RED: begin
						search.key_red = cfg_data[7:0];
					end
					CFG_KEY_GREEN: begin
						search.key_green = cfg_data[7:0];
					end
					CFG_KEY_BLUE: begin
						search.key_blue = cfg_data[7:0];
					end
					CFG_KEY_ENABLE: begin
						search.key_enable = cfg_data[0];
					end
					CFG_FRAME_WIDTH: begin
						search.frame_width = cfg_data;
					end
					CFG_FRAME_HEIGHT: begin
						search.frame_height = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (pix_valid && !pix_stall)
				track_pixel(pixel_red, pixel_green, pixel_blue);
			mismatches    <= errs;
			boxes_waiting <= expected_boxes.size();
		end
	end

endmodule

// File: test/testbench.sv
module testbench;
	import ckbb_pkg::*;

	localparam int       SPAN         = 1 << COORD_BITS_DEF;
	localparam int       MAX_CODE     = (1 << CFG_DATA_W) - 1;
	localparam int       HOLD_CYCLES  = 300;
	localparam int       CYCLE_LIMIT  = 1_000_000;
	localparam int       RANDOM_ITEMS = 1800;
	localparam cfg_idx_t CFG_SPARE_A  = 3'd6;
	localparam cfg_idx_t CFG_SPARE_B  = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pix_valid;
	logic                  pix_stall;
	logic [7:0]            pixel_red;
	logic [7:0]            pixel_green;
	logic [7:0]            pixel_blue;
	logic [7:0]            pixel_alpha;
	logic                  res_valid;
	logic                  res_stall;
	logic                  found;
	logic [OUT_W-1:0]      box_min_col;
	logic [OUT_W-1:0]      box_max_col;
	logic [OUT_W-1:0]      box_min_row;
	logic [OUT_W-1:0]      box_max_row;
	logic [OUT_W-1:0]      center_col;
	logic [OUT_W-1:0]      center_row;

	int         mismatches;
	int         boxes_waiting;
	int         cycle_count = 0;
	bit         calm = 1'b1;
	bit         hold_wanted = 1'b0;
	int         match_pct = 20;
	logic [7:0] key_r = '0;
	logic [7:0] key_g = '0;
	logic [7:0] key_b = '0;

	color_key_bounding_box_top uut (.*);

	bounding_box_checker checker_inst (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [CFG_DATA_W-1:0] size_code(int eff);
		if (eff == 1 && $urandom_range(0, 1) == 1)
			return '0;
		if (eff == SPAN && $urandom_range(0, 1) == 1)
			return CFG_DATA_W'($urandom_range(SPAN + 1, MAX_CODE));
		return CFG_DATA_W'(eff);
	endfunction

	function automatic logic [7:0] key_byte();
		int pick;
		pick = $urandom_range(0, 5);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_search(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic key_en,
			int w, int h);
		key_r = r;
		key_g = g;
		key_b = b;
		write_reg(CFG_KEY_RED, {5'($urandom), r});
		write_reg(CFG_KEY_GREEN, {5'($urandom), g});
		write_reg(CFG_KEY_BLUE, {5'($urandom), b});
		write_reg(CFG_KEY_ENABLE, {12'($urandom), key_en});
		write_reg(CFG_FRAME_WIDTH, size_code(w));
		write_reg(CFG_FRAME_HEIGHT, size_code(h));
		if ($urandom_range(0, 3) == 0)
			write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
				CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid   <= 1'b1;
		pixel_red   <= r;
		pixel_green <= g;
		pixel_blue  <= b;
		pixel_alpha <= a;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
	endtask

	task automatic send_pixels(int n);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] flip;
		int         pick;
		int         lane;
		repeat (n) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < match_pct + 10) begin
				r = key_r;
				g = key_g;
				b = key_b;
			end
			// Near misses differ from the key in a single bit.
			if (pick >= match_pct && pick < match_pct + 10) begin
				flip = 8'd1 << $urandom_range(0, 7);
				lane = $urandom_range(0, 2);
				if (lane == 0)
					r = r ^ flip;
				else if (lane == 1)
					g = g ^ flip;
				else
					b = b ^ flip;
			end
			send_pixel(r, g, b, 8'($urandom));
		end
	endtask

	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (boxes_waiting != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int  k;
		bit  held;
		held = 1'b0;
		res_stall <= 1'b0;
		forever begin
			if (hold_wanted && !held) begin
				held = 1'b1;
				k = HOLD_CYCLES;
			end else if (calm) begin
				k = 0;
			end else begin
				k = $urandom_range(0, 4);
			end
			if (k > 0) begin
				res_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
		end
	end

	initial begin
		int done_items;
		int frames;
		int n;
		int w;
		int h;
		int pick;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_KEY_RED;
		cfg_data    <= '0;
		pix_valid   <= 1'b0;
		pixel_red   <= '0;
		pixel_green <= '0;
		pixel_blue  <= '0;
		pixel_alpha <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Part of a row at the reset frame size, with the key still disabled.
		send_pixels(200);
		drain();
		calm = 1'b0;

		program_search(8'd10, 8'd20, 8'd30, 1'b1, 3, 2);
		send_pixel(8'd11, 8'd20, 8'd30, 8'h00);
		send_pixel(8'd10, 8'd20, 8'd30, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'hFF, 8'h5A);
		send_pixel(8'd10, 8'd20, 8'd30, 8'hFF);
		send_pixel(8'd10, 8'd20, 8'd31, 8'h00);
		send_pixel(8'd10, 8'd21, 8'd30, 8'hFF);
		drain();

		program_search(8'd10, 8'd20, 8'd30, 1'b0, 1, 1);
		send_pixel(8'd10, 8'd20, 8'd30, 8'hFF);
		drain();

		program_search(8'hFF, 8'hFF, 8'hFF, 1'b1, 1, 1);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		drain();
		program_search(8'h00, 8'h00, 8'h00, 1'b1, 1, 1);
		send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		drain();

		// The frame shrinks and the key changes while the counters sit mid-row.
		program_search(8'd1, 8'd2, 8'd3, 1'b1, 8, 2);
		send_pixel(8'd9, 8'd9, 8'd9, 8'h00);
		send_pixel(8'd9, 8'd9, 8'd9, 8'h00);
		send_pixel(8'd9, 8'd9, 8'd9, 8'h00);
		send_pixel(8'd9, 8'd9, 8'd9, 8'h00);
		send_pixel(8'd1, 8'd2, 8'd3, 8'h00);
		drain();
		program_search(8'd4, 8'd5, 8'd6, 1'b1, 3, 2);
		send_pixel(8'd4, 8'd5, 8'd6, 8'd7);
		send_pixel(8'd0, 8'd0, 8'd0, 8'h00);
		send_pixel(8'd4, 8'd5, 8'd6, 8'h00);
		send_pixel(8'd1, 8'd2, 8'd3, 8'h00);
		drain();

		// The receiver holds off while one-pixel frames keep coming.
		calm = 1'b1;
		match_pct = 50;
		program_search(key_byte(), key_byte(), key_byte(), 1'b1, 1, 1);
		hold_wanted = 1'b1;
		send_pixels(40);
		drain();

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			w = (pick < 6) ? $urandom_range(1, 6) : $urandom_range(7, 24);
			h = $urandom_range(1, 5);
			calm = ($urandom_range(0, 4) == 0);
			match_pct = $urandom_range(0, 60);
			program_search(key_byte(), key_byte(), key_byte(), $urandom_range(0, 6) != 0,
				w, h);
			frames = $urandom_range(1, 3);
			n = frames * w * h;
			if (w * h > 1 && $urandom_range(0, 3) == 0)
				n += $urandom_range(1, w * h - 1);
			send_pixels(n);
			done_items += n;
			drain();
		end

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
